// ----- rtl/sgr_pkg.sv -----
`default_nettype none

package sgr_pkg;

	// display size
	localparam int SCREEN_WIDTH  = 240;
	localparam int SCREEN_HEIGHT = 240;

	// coordinate width wide enough for a start plus six or eight scale steps
	localparam int COORD_W = 12;
	typedef logic [COORD_W-1:0] coord_t;

	localparam coord_t SCR_W = coord_t'(SCREEN_WIDTH);
	localparam coord_t SCR_H = coord_t'(SCREEN_HEIGHT);

	// glyph geometry
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
	localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

	// character codes
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;

	localparam logic [2:0] MINUS_ROW = 3'd3;
	localparam logic [2:0] DOT_ROW   = 3'd6;
	localparam logic [4:0] MINUS_BITS = 5'h1F;
	localparam logic [4:0] DOT_BITS   = 5'h04;

	// 5x7 digit font, leftmost column in bit 4
	localparam logic [4:0] DIGIT_ROWS [10][7] = '{
		'{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
		'{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
		'{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
		'{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
		'{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
		'{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
		'{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
		'{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
		'{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  w;
		logic [7:0]  h;
		logic [15:0] color;
		logic        last;
	} rect_t;

	typedef struct packed {
		logic  valid;
		rect_t rect;
	} push_t;

	function automatic logic [4:0] glyph_row(input logic [7:0] code, input logic [2:0] row);
		logic [4:0] bits;
		bits = '0;
		if (code inside {[CHAR_ZERO:CHAR_NINE]}) begin
			bits = DIGIT_ROWS[code[3:0]][row];
		end else if (code == CHAR_MINUS && row == MINUS_ROW) begin
			bits = MINUS_BITS;
		end else if (code == CHAR_DOT && row == DOT_ROW) begin
			bits = DOT_BITS;
		end
		return bits;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/sgr_in_if.sv -----
`default_nettype none

interface sgr_in_if;
	logic        valid;
	logic        ready;
	logic        first_of_string;
	logic [9:0]  start_x;
	logic [9:0]  row_y;
	logic [7:0]  char_code;
	logic [15:0] fg_color;
	logic [15:0] bg_color;
	logic [7:0]  scale;

	modport source (
		output valid, first_of_string, start_x, row_y, char_code, fg_color, bg_color, scale,
		input  ready
	);

	modport sink (
		input  valid, first_of_string, start_x, row_y, char_code, fg_color, bg_color, scale,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/sgr_out_if.sv -----
`default_nettype none

interface sgr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rect_x;
	logic [7:0]  rect_y;
	logic [7:0]  rect_w;
	logic [7:0]  rect_h;
	logic [15:0] rect_color;
	logic        last_rect;

	modport source (
		output valid, rect_x, rect_y, rect_w, rect_h, rect_color, last_rect,
		input  ready
	);

	modport sink (
		input  valid, rect_x, rect_y, rect_w, rect_h, rect_color, last_rect,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/sgr_clip_unit.sv -----
`default_nettype none

// shared on-screen test and edge clip, used for the cell and for every pixel
module sgr_clip_unit import sgr_pkg::*; (
	input  coord_t     px,
	input  coord_t     py,
	input  coord_t     len_x,
	input  coord_t     len_y,
	output logic       hit,
	output logic [7:0] w,
	output logic [7:0] h
);

	coord_t room_x;
	coord_t room_y;

	assign room_x = SCR_W - px;
	assign room_y = SCR_H - py;
	assign hit    = (px < SCR_W) && (py < SCR_H);

	assign w = (len_x > room_x) ? room_x[7:0] : len_x[7:0];
	assign h = (len_y > room_y) ? room_y[7:0] : len_y[7:0];

endmodule

`default_nettype wire

// ----- rtl/sgr_seq.sv -----
`default_nettype none

module sgr_seq import sgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sgr_in_if.sink     char_in,
	input  logic       out_free,
	output push_t      push
);

	seq_state_t state_q, state_nxt;
	logic       halted_q;
	logic [9:0] cursor_q;

	// captured transaction
	logic        first_q;
	logic [9:0]  sx_q;
	logic [9:0]  y_q;
	logic [7:0]  code_q;
	logic [15:0] fg_q;
	logic [15:0] bg_q;
	logic [7:0]  s_q;

	// walk position
	logic [2:0] row_q;
	logic [2:0] col_q;
	coord_t     px_q;
	coord_t     py_q;
	coord_t     xb_q;
	rect_t      pend_q;

	coord_t     x_eff;
	coord_t     y_ext;
	coord_t     s_ext;
	coord_t     adv;
	logic       start_ok;
	logic       cont_ok;
	logic       fit_ok;
	logic       check_pass;

	coord_t     cu_px, cu_py, cu_lx, cu_ly;
	logic       cu_hit;
	logic [7:0] cu_w, cu_h;

	logic [4:0] bits;
	logic       lit;
	logic       cand;
	logic       stall;
	logic       advance;
	logic       last_pos;
	logic       accept;

	assign y_ext = coord_t'(y_q);
	assign s_ext = coord_t'(s_q);
	assign adv   = (s_ext << 2) + (s_ext << 1);
	assign x_eff = first_q ? coord_t'(sx_q) : coord_t'(cursor_q);

	assign start_ok   = (s_q != '0) && (coord_t'(sx_q) < SCR_W) && (y_ext < SCR_H);
	assign cont_ok    = !halted_q && (s_q != '0) && (y_ext < SCR_H);
	assign fit_ok     = (x_eff <= SCR_W) && (adv <= SCR_W - x_eff);
	assign check_pass = (first_q ? start_ok : cont_ok) && fit_ok;

	assign bits     = glyph_row(code_q, row_q);
	assign lit      = bits[LAST_COL - col_q];
	assign last_pos = (row_q == LAST_ROW) && (col_q == LAST_COL);

	always_comb begin
		if (state_q == ST_CHECK) begin
			cu_px = x_eff;
			cu_py = y_ext;
			cu_lx = adv;
			cu_ly = coord_t'({s_q, 3'b000});
		end else begin
			cu_px = px_q;
			cu_py = py_q;
			cu_lx = s_ext;
			cu_ly = s_ext;
		end
	end

	sgr_clip_unit u_clip (
		.px    (cu_px),
		.py    (cu_py),
		.len_x (cu_lx),
		.len_y (cu_ly),
		.hit   (cu_hit),
		.w     (cu_w),
		.h     (cu_h)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (char_in.valid) state_nxt = ST_CHECK;
			ST_CHECK: state_nxt = check_pass ? ST_WALK : ST_IDLE;
			ST_WALK:  if (advance && last_pos) state_nxt = ST_FLUSH;
			ST_FLUSH: if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		char_in.ready = 1'b0;
		cand          = 1'b0;
		stall         = 1'b0;
		advance       = 1'b0;
		push.valid    = 1'b0;
		push.rect     = pend_q;
		push.rect.last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				char_in.ready = 1'b1;
			end
			ST_WALK: begin
				cand       = lit && cu_hit;
				stall      = cand && !out_free;
				advance    = !stall;
				push.valid = cand && out_free;
			end
			ST_FLUSH: begin
				push.valid     = out_free;
				push.rect.last = 1'b1;
			end
			default: begin
				char_in.ready = 1'b0;
			end
		endcase
	end

	assign accept = char_in.valid && char_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			halted_q <= 1'b1;
			cursor_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CHECK) begin
				halted_q <= !check_pass;
				if (check_pass) begin
					cursor_q <= 10'(x_eff + adv);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q <= char_in.first_of_string;
			sx_q    <= char_in.start_x;
			y_q     <= char_in.row_y;
			code_q  <= char_in.char_code;
			fg_q    <= char_in.fg_color;
			bg_q    <= char_in.bg_color;
			s_q     <= char_in.scale;
		end
		if (state_q == ST_CHECK) begin
			// background cell is always on screen once the checks pass
			pend_q.x     <= x_eff[7:0];
			pend_q.y     <= y_q[7:0];
			pend_q.w     <= cu_w;
			pend_q.h     <= cu_h;
			pend_q.color <= bg_q;
			pend_q.last  <= 1'b0;
			px_q  <= x_eff;
			py_q  <= y_ext;
			xb_q  <= x_eff;
			row_q <= '0;
			col_q <= '0;
		end else if (advance) begin
			if (cand) begin
				pend_q.x     <= px_q[7:0];
				pend_q.y     <= py_q[7:0];
				pend_q.w     <= cu_w;
				pend_q.h     <= cu_h;
				pend_q.color <= fg_q;
				pend_q.last  <= 1'b0;
			end
			if (col_q == LAST_COL) begin
				col_q <= '0;
				row_q <= row_q + 3'd1;
				px_q  <= xb_q;
				py_q  <= py_q + s_ext;
			end else begin
				col_q <= col_q + 3'd1;
				px_q  <= px_q + s_ext;
			end
		end
	end

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> out_free)
		else $error("rectangle pushed into a full output register");

	a_last_only_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && push.rect.last) |-> (state_q == ST_FLUSH))
		else $error("last rectangle flagged outside the flush step");

	a_push_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (push.rect.w != '0 && push.rect.h != '0 &&
			coord_t'(push.rect.x) < SCR_W))
		else $error("empty or off-screen rectangle pushed");

	a_walk_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !halted_q)
		else $error("glyph walk while the string is halted");

	a_check_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CHECK))
		else $error("accepted transaction not checked");

endmodule

`default_nettype wire

// ----- rtl/scaled_glyph_rect_rasterizer.sv -----
// channel   | dir | payload                                          | handshake
// ----------+-----+--------------------------------------------------+-------------
// char_in   | in  | first_of_string start_x row_y char_code fg/bg    | valid/ready
//           |     | colours, scale                                   |
// rect_out  | out | rect_x rect_y rect_w rect_h rect_color last_rect | valid/ready
//
// one character, with a free output, runs through: accept, one check step,
// 35 glyph positions walked one a cycle through the shared clip unit, one flush
// each stall on rect_out holds the walk at the position waiting to push
// a character that gives no rectangles is finished after the check step
// arst_n clears the sequencer, the cursor to 0 and marks no string active
`default_nettype none

module scaled_glyph_rect_rasterizer import sgr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sgr_in_if.sink    char_in,
	sgr_out_if.source rect_out
);

	push_t push;
	rect_t out_q;
	logic  out_valid_q;
	logic  out_free;

	// the output register takes a new rectangle when empty or draining this cycle
	assign out_free = !out_valid_q || rect_out.ready;

	sgr_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_in),
		.out_free (out_free),
		.push     (push)
	);

	// output valid flag, control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid) begin
			out_valid_q <= 1'b1;
		end else if (rect_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// rectangle payload, held until the transaction completes
	always_ff @(posedge clk) begin
		if (push.valid) begin
			out_q <= push.rect;
		end
	end

	assign rect_out.valid      = out_valid_q;
	assign rect_out.rect_x     = out_q.x;
	assign rect_out.rect_y     = out_q.y;
	assign rect_out.rect_w     = out_q.w;
	assign rect_out.rect_h     = out_q.h;
	assign rect_out.rect_color = out_q.color;
	assign rect_out.last_rect  = out_q.last;

endmodule

`default_nettype wire
